// ===== rtl/core/svt_pkg.sv =====
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types, codes and defaults for the sorted value table.
// ----------------------------------------------------------------------------
package svt_pkg;

  localparam int DepthDefault = 16;

  localparam int CmdW   = 2;
  localparam int ValueW = 32;
  localparam int KeyW   = 32;
  localparam int PosW   = 4;
  localparam int StatW  = 2;
  localparam int CountW = 5;

  localparam logic [CmdW-1:0] CMD_ADD    = 2'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ   = 2'd2;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatW-1:0] ST_NOKEY = 2'd2;
  localparam logic [StatW-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic signed [KeyW-1:0]   key;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic less;
    logic match;
  } cmp_t;

endpackage

// ===== rtl/core/sorted_value_table.sv =====
// ----------------------------------------------------------------------------
// sorted_value_table
// Table of up to DEPTH (value, key) pairs kept in ascending signed order.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; busy stays high
// until its single result beat, which is shown with done high for exactly one
// cycle and cannot be held off by the receiver. Entries live in one RAM with a
// registered read port, and the sequencer visits one entry at a time, reading
// it and then evaluating it, through a shared compare unit. A read in range
// visits the addressed entry; an add walks down from the last entry, moves up
// each entry not less than the new value and then writes the new one (at once
// on an empty table, not at all on a full one); a remove visits every entry
// (none on an empty table). The table is empty after reset with no clearing pass.
// ----------------------------------------------------------------------------
module sorted_value_table #(
  parameter int DEPTH = svt_pkg::DepthDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [svt_pkg::CmdW-1:0]           command,
  input  logic signed [svt_pkg::ValueW-1:0]  value,
  input  logic signed [svt_pkg::KeyW-1:0]    key,
  input  logic [svt_pkg::PosW-1:0]           position,
  output logic                               busy,
  output logic                               done,
  output logic signed [svt_pkg::ValueW-1:0]  read_value,
  output logic [svt_pkg::StatW-1:0]          status,
  output logic [svt_pkg::CountW-1:0]         entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > svt_pkg::PosW) ? CW : svt_pkg::PosW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0]                         state, state_next;
  logic [svt_pkg::CmdW-1:0]           op, op_next;
  logic signed [svt_pkg::ValueW-1:0]  val, val_next;
  logic signed [svt_pkg::KeyW-1:0]    kval, kval_next;
  logic [AW-1:0]                      idx, idx_next;
  logic [CW-1:0]                      count, count_next;
  logic                               found, found_next;
  logic                               done_next;
  logic signed [svt_pkg::ValueW-1:0]  read_value_next;
  logic [svt_pkg::StatW-1:0]          status_next;

  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  svt_pkg::entry_t                    ram_wdata;
  svt_pkg::entry_t                    ram_rdata;
  svt_pkg::entry_t                    new_entry;
  svt_pkg::cmp_t                      cmp;
  logic                               hit;

  svt_ram #(
    .WIDTH (svt_pkg::EntryW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  svt_cmp u_cmp (
    .entry  (ram_rdata),
    .value  (val),
    .key    (kval),
    .result (cmp)
  );

  assign new_entry.value = val;
  assign new_entry.key   = kval;
  assign hit             = found | cmp.match;

  assign busy        = (state != S_IDLE);
  assign entry_count = svt_pkg::CountW'(count);

  always_comb begin
    state_next      = state;
    op_next         = op;
    val_next        = val;
    kval_next       = kval;
    idx_next        = idx;
    count_next      = count;
    found_next      = found;
    done_next       = 1'b0;
    read_value_next = read_value;
    status_next     = status;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = new_entry;
    case (state)
      S_IDLE: begin
        if (start) begin
          op_next         = command;
          val_next        = value;
          kval_next       = key;
          read_value_next = '0;
          case (command)
            svt_pkg::CMD_ADD: begin
              if (count == CW'(DEPTH)) begin
                done_next   = 1'b1;
                status_next = svt_pkg::ST_FULL;
              end else if (count == '0) begin
                ram_we          = 1'b1;
                ram_waddr       = '0;
                ram_wdata.value = value;
                ram_wdata.key   = key;
                count_next      = count + CW'(1);
                done_next       = 1'b1;
                status_next     = svt_pkg::ST_OK;
              end else begin
                idx_next   = AW'(count - CW'(1));
                state_next = S_RD;
              end
            end
            svt_pkg::CMD_REMOVE: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = svt_pkg::ST_NOKEY;
              end else begin
                idx_next   = '0;
                found_next = 1'b0;
                state_next = S_RD;
              end
            end
            svt_pkg::CMD_READ: begin
              if (PW'(position) < PW'(count)) begin
                idx_next   = AW'(position);
                state_next = S_RD;
              end else begin
                done_next   = 1'b1;
                status_next = svt_pkg::ST_RANGE;
              end
            end
            default: begin
              done_next   = 1'b1;
              status_next = svt_pkg::ST_OK;
            end
          endcase
        end
      end
      S_RD: begin
        state_next = S_EV;
      end
      S_EV: begin
        case (op)
          svt_pkg::CMD_ADD: begin
            ram_we    = 1'b1;
            ram_waddr = idx + AW'(1);
            if (cmp.less) begin
              count_next  = count + CW'(1);
              done_next   = 1'b1;
              status_next = svt_pkg::ST_OK;
              state_next  = S_IDLE;
            end else begin
              ram_wdata = ram_rdata;
              if (idx == '0) begin
                state_next = S_WR;
              end else begin
                idx_next   = idx - AW'(1);
                state_next = S_RD;
              end
            end
          end
          svt_pkg::CMD_REMOVE: begin
            // once the key is found every later entry moves down one slot
            if (found) begin
              ram_we    = 1'b1;
              ram_waddr = idx - AW'(1);
              ram_wdata = ram_rdata;
            end
            found_next = hit;
            if (idx == AW'(count - CW'(1))) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
              if (hit) begin
                count_next  = count - CW'(1);
                status_next = svt_pkg::ST_OK;
              end else begin
                status_next = svt_pkg::ST_NOKEY;
              end
            end else begin
              idx_next   = idx + AW'(1);
              state_next = S_RD;
            end
          end
          default: begin
            read_value_next = ram_rdata.value;
            status_next     = svt_pkg::ST_OK;
            done_next       = 1'b1;
            state_next      = S_IDLE;
          end
        endcase
      end
      S_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = '0;
        count_next  = count + CW'(1);
        done_next   = 1'b1;
        status_next = svt_pkg::ST_OK;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      found <= found_next;
    end
    op         <= op_next;
    val        <= val_next;
    kval       <= kval_next;
    idx        <= idx_next;
    read_value <= read_value_next;
    status     <= status_next;
  end

endmodule

// ===== rtl/core/svt_ram.sv =====
// ----------------------------------------------------------------------------
// svt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/svt_cmp.sv =====
// ----------------------------------------------------------------------------
// svt_cmp
// Shared compare unit: signed value order and key equality of one entry.
// ----------------------------------------------------------------------------
module svt_cmp (
  input  svt_pkg::entry_t                   entry,
  input  logic signed [svt_pkg::ValueW-1:0] value,
  input  logic signed [svt_pkg::KeyW-1:0]   key,
  output svt_pkg::cmp_t                     result
);

  assign result.less  = $signed(entry.value) < $signed(value);
  assign result.match = (entry.key == key);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted value table.
// ----------------------------------------------------------------------------
// A short command script covers the empty and full table, the extreme values
// and keys, equal values, duplicate keys and the unused command code. It is
// followed by random commands in alternating fill and drain phases. A mirror
// of the table in the bench works out the answer of every accepted command,
// and each result beat is compared field by field with the oldest answer.
// ----------------------------------------------------------------------------
module tb;
  import svt_pkg::*;

  localparam int TableDepth = DepthDefault;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic signed [ValueW-1:0] read_value;
    logic [StatW-1:0]         status;
    logic [CountW-1:0]        entry_count;
  } answer_t;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic signed [ValueW-1:0] val;
    logic signed [KeyW-1:0]   k;
    logic [PosW-1:0]          pos;
    logic [7:0]               reps;
    logic                     typed;
    answer_t                  want;
  } row_t;

  localparam row_t SCRIPT [0:21] = '{
    '{CMD_READ,   32'h0,         32'h0,         4'd0,  8'd1,  1'b1, '{32'h0, ST_RANGE, 5'd0}},
    '{CMD_REMOVE, 32'h0,         32'd5,         4'd0,  8'd1,  1'b1, '{32'h0, ST_NOKEY, 5'd0}},
    '{CmdUnused,  32'h0,         32'h0,         4'd0,  8'd1,  1'b1, '{32'h0, ST_OK, 5'd0}},
    '{CMD_ADD,    32'h7FFF_FFFF, 32'h8000_0000, 4'd0,  8'd1,  1'b1, '{32'h0, ST_OK, 5'd1}},
    '{CMD_ADD,    32'h8000_0000, 32'h7FFF_FFFF, 4'd0,  8'd1,  1'b1, '{32'h0, ST_OK, 5'd2}},
    '{CMD_ADD,    32'h0,         32'h0,         4'd0,  8'd1,  1'b1, '{32'h0, ST_OK, 5'd3}},
    '{CMD_READ,   32'h0,         32'h0,         4'd0,  8'd1,  1'b1,
      '{32'h8000_0000, ST_OK, 5'd3}},
    '{CMD_READ,   32'h0,         32'h0,         4'd2,  8'd1,  1'b1,
      '{32'h7FFF_FFFF, ST_OK, 5'd3}},
    '{CMD_READ,   32'h0,         32'h0,         4'd3,  8'd1,  1'b1, '{32'h0, ST_RANGE, 5'd3}},
    '{CMD_ADD,    32'h0,         32'd7,         4'd0,  8'd1,  1'b0, '0},
    '{CMD_ADD,    32'h0002_0000, 32'h0,         4'd0,  8'd1,  1'b0, '0},
    '{CMD_REMOVE, 32'h0,         32'h0,         4'd0,  8'd1,  1'b0, '0},
    '{CMD_READ,   32'h0,         32'h0,         4'd1,  8'd1,  1'b0, '0},
    '{CMD_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0,  8'd1,  1'b0, '0},
    '{CMD_ADD,    32'h0001_0000, 32'h0000_0100, 4'd0,  8'd11, 1'b0, '0},
    '{CMD_ADD,    32'h5,         32'h5,         4'd0,  8'd1,  1'b1, '{32'h0, ST_FULL, 5'd16}},
    '{CMD_READ,   32'h0,         32'h0,         4'd15, 8'd1,  1'b0, '0},
    '{CmdUnused,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 8'd1,  1'b1, '{32'h0, ST_OK, 5'd16}},
    '{CMD_REMOVE, 32'h0,         32'h8000_0000, 4'd0,  8'd1,  1'b0, '0},
    '{CMD_REMOVE, 32'h0,         32'h0BAD_F00D, 4'd0,  8'd1,  1'b1, '{32'h0, ST_NOKEY, 5'd15}},
    '{CMD_READ,   32'h0,         32'h0,         4'd15, 8'd1,  1'b1, '{32'h0, ST_RANGE, 5'd15}},
    '{CMD_READ,   32'h0,         32'h0,         4'd14, 8'd1,  1'b0, '0}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [CmdW-1:0]          command = CMD_READ;
  logic signed [ValueW-1:0] value = '0;
  logic signed [KeyW-1:0]   key = '0;
  logic [PosW-1:0]          position = '0;
  logic                     busy;
  logic                     done;
  logic signed [ValueW-1:0] read_value;
  logic [StatW-1:0]         status;
  logic [CountW-1:0]        entry_count;

  logic signed [ValueW-1:0] mirror_values [TableDepth];
  logic signed [KeyW-1:0]   mirror_keys [TableDepth];
  int                       mirror_count = 0;
  answer_t                  pending_answers [$];
  int                       mismatch_count = 0;

  sorted_value_table #(.DEPTH(TableDepth)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .command     (command),
    .value       (value),
    .key         (key),
    .position    (position),
    .busy        (busy),
    .done        (done),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic answer_t table_apply(input logic [CmdW-1:0] cmd,
                                          input logic signed [ValueW-1:0] val,
                                          input logic signed [KeyW-1:0] k,
                                          input logic [PosW-1:0] pos);
    answer_t ans;
    int slot;
    int i;
    ans = '0;
    case (cmd)
      CMD_ADD: begin
        if (mirror_count >= TableDepth) begin
          ans.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < mirror_count && mirror_values[slot] < val) slot++;
          for (i = mirror_count; i > slot; i--) begin
            mirror_values[i] = mirror_values[i-1];
            mirror_keys[i]   = mirror_keys[i-1];
          end
          mirror_values[slot] = val;
          mirror_keys[slot]   = k;
          mirror_count++;
        end
      end
      CMD_REMOVE: begin
        slot = 0;
        while (slot < mirror_count && mirror_keys[slot] !== k) slot++;
        if (slot >= mirror_count) begin
          ans.status = ST_NOKEY;
        end else begin
          for (i = slot; i + 1 < mirror_count; i++) begin
            mirror_values[i] = mirror_values[i+1];
            mirror_keys[i]   = mirror_keys[i+1];
          end
          mirror_count--;
        end
      end
      CMD_READ: begin
        if (pos < mirror_count) ans.read_value = mirror_values[pos];
        else ans.status = ST_RANGE;
      end
      default: ;
    endcase
    ans.entry_count = mirror_count[CountW-1:0];
    return ans;
  endfunction

  // called just after a rising edge; returns at the edge that takes the beat
  task automatic put_beat(input logic [CmdW-1:0] cmd, input logic signed [ValueW-1:0] val,
                          input logic signed [KeyW-1:0] k, input logic [PosW-1:0] pos,
                          input int gap, input logic typed, input answer_t want);
    answer_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command  <= cmd;
    value    <= val;
    key      <= k;
    position <= pos;
    start    <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    predicted = table_apply(cmd, val, k, pos);
    pending_answers.push_back(typed ? want : predicted);
  endtask

  task automatic random_beat(input bit filling, input bit burst);
    int r;
    logic [CmdW-1:0] cmd;
    logic signed [ValueW-1:0] val;
    logic signed [KeyW-1:0] k;
    logic [PosW-1:0] pos;
    r = $urandom_range(0, 99);
    if (filling) begin
      cmd = (r < 60) ? CMD_ADD : (r < 75) ? CMD_REMOVE : (r < 95) ? CMD_READ : CmdUnused;
    end else begin
      cmd = (r < 15) ? CMD_ADD : (r < 70) ? CMD_REMOVE : (r < 95) ? CMD_READ : CmdUnused;
    end
    r = $urandom_range(0, 99);
    if (r < 30) begin
      val = ($signed($urandom_range(0, 6)) - 3) <<< 16;
    end else if (r < 40) begin
      case ($urandom_range(0, 3))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = 32'hFFFF_FFFF;
        default: val = 32'h0;
      endcase
    end else if (r < 50 && mirror_count > 0) begin
      val = mirror_values[$urandom_range(0, mirror_count - 1)];
    end else begin
      val = $urandom;
    end
    r = $urandom_range(0, 99);
    if (r < 40 && mirror_count > 0) begin
      k = mirror_keys[$urandom_range(0, mirror_count - 1)];
    end else if (r < 80) begin
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 1)) k = -k;
    end else if (r < 90) begin
      case ($urandom_range(0, 3))
        0: k = 32'h8000_0000;
        1: k = 32'h7FFF_FFFF;
        2: k = 32'hFFFF_FFFF;
        default: k = 32'h0;
      endcase
    end else begin
      k = $urandom;
    end
    if ($urandom_range(0, 1) || mirror_count == 0) pos = $urandom_range(0, 15);
    else pos = $urandom_range(0, mirror_count - 1);
    put_beat(cmd, val, k, pos, burst ? 0 : $urandom_range(0, 7), 1'b0, '0);
  endtask

  // result beats
  always @(negedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result beat with none pending: read_value %h status %0d count %0d",
                 $time, read_value, status, entry_count);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value, read_value);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          mismatch_count++;
        end
        if (entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                   entry_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int i;
    int j;
    int phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (i = 0; i < $size(SCRIPT); i++) begin
      for (j = 0; j < SCRIPT[i].reps; j++) begin
        put_beat(SCRIPT[i].cmd, SCRIPT[i].val + j, SCRIPT[i].k + j, SCRIPT[i].pos,
                 $urandom_range(0, 7), SCRIPT[i].typed, SCRIPT[i].want);
      end
    end
    for (phase = 0; phase < 29; phase++) begin
      for (j = 0; j < 50; j++) random_beat(phase % 2 == 0, phase % 4 == 1);
    end
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
